[rtl/lrupl_pkg.sv]
// ---------------------------------------------------------------------------
// lrupl_pkg
// command codes and field widths for the lru page list
// ---------------------------------------------------------------------------
`default_nettype none

package lrupl_pkg;

    localparam int CMD_W  = 3;
    localparam int SLOT_W = 5;
    localparam int ADDR_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 3'd4;

endpackage

`default_nettype wire

[rtl/lrupl_ram.sv]
// ---------------------------------------------------------------------------
// lrupl_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module lrupl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/lru_page_list_victim_select.sv]
// ---------------------------------------------------------------------------
// lru_page_list_victim_select
// recency list of page slots with address lookup and victim selection
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one result on done/found/result_slot, one cycle wide, and the
// receiver cannot stall it. Links, addresses and flags live in rams with one
// write port and one registered read port, so a request runs as a short
// sequence: set flags is written from idle, remove passes through unlink,
// insert through unlink, link prev and link self, and find or victim walk
// the list with one ram read per visited entry (at most SLOTS entries). After
// reset the block clears its flag rams with busy high before it takes the
// first request.
`default_nettype none

module lru_page_list_victim_select #(
    parameter int SLOTS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [lrupl_pkg::CMD_W-1:0]     cmd,
    input  wire logic [lrupl_pkg::SLOT_W-1:0]    slot,
    input  wire logic [lrupl_pkg::ADDR_W-1:0]    page_address,
    input  wire logic                            swapped,
    input  wire logic                            resident,
    output logic                                 busy,
    output logic                                 done,
    output logic                                 found,
    output logic      [lrupl_pkg::SLOT_W-1:0]    result_slot
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam int WIDE  = (PTR_W > lrupl_pkg::SLOT_W) ? PTR_W : lrupl_pkg::SLOT_W;
    localparam logic [PTR_W-1:0] NONE = PTR_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UNLINK,
        S_LINK_PREV,
        S_LINK_SELF,
        S_FIND,
        S_VICTIM
    } state_t;

    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                head_reg, head_next;
    logic [PTR_W-1:0]                tail_reg, tail_next;
    logic [PTR_W-1:0]                cur_reg, cur_next;
    logic [PTR_W-1:0]                steps_reg, steps_next;
    logic [lrupl_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [IDX_W-1:0]                slot_reg, slot_next;
    logic [lrupl_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;
    logic                            done_reg, done_next;
    logic                            found_reg, found_next;
    logic [lrupl_pkg::SLOT_W-1:0]    result_reg, result_next;

    logic [WIDE-1:0]                 slot_wide;
    logic [IDX_W-1:0]                slot_idx;
    logic                            slot_ok;
    logic [WIDE-1:0]                 cur_wide;

    logic [IDX_W-1:0]                rd_addr;

    logic                            next_we, prev_we, addr_we, inl_we, attr_we;
    logic [IDX_W-1:0]                next_wa, prev_wa, inl_wa, attr_wa;
    logic [PTR_W-1:0]                next_wd, prev_wd;
    logic [0:0]                      inl_wd;
    logic [1:0]                      attr_wd;

    logic [PTR_W-1:0]                next_q, prev_q;
    logic [lrupl_pkg::ADDR_W-1:0]    addr_q;
    logic [0:0]                      inl_q;
    logic [1:0]                      attr_q;

    assign slot_wide = WIDE'(slot);
    assign slot_idx  = slot_wide[IDX_W-1:0];
    assign slot_ok   = slot_wide < WIDE'(SLOTS);
    assign cur_wide  = WIDE'(cur_reg);

    lrupl_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .raddr (rd_addr),
        .rdata (next_q)
    );

    lrupl_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (rd_addr),
        .rdata (prev_q)
    );

    lrupl_ram #(.WIDTH(lrupl_pkg::ADDR_W), .DEPTH(SLOTS)) u_addr (
        .clk   (clk),
        .we    (addr_we),
        .waddr (slot_reg),
        .wdata (addr_reg),
        .raddr (rd_addr),
        .rdata (addr_q)
    );

    lrupl_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_inl (
        .clk   (clk),
        .we    (inl_we),
        .waddr (inl_wa),
        .wdata (inl_wd),
        .raddr (rd_addr),
        .rdata (inl_q)
    );

    // attr bit 1 swapped, bit 0 resident
    lrupl_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_attr (
        .clk   (clk),
        .we    (attr_we),
        .waddr (attr_wa),
        .wdata (attr_wd),
        .raddr (rd_addr),
        .rdata (attr_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        cmd_next    = cmd_reg;
        slot_next   = slot_reg;
        addr_next   = addr_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        found_next  = 1'b0;
        result_next = '0;

        rd_addr = slot_idx;
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = head_reg;
        prev_we = 1'b0;
        prev_wa = slot_reg;
        prev_wd = NONE;
        addr_we = 1'b0;
        inl_we  = 1'b0;
        inl_wa  = slot_reg;
        inl_wd  = 1'b0;
        attr_we = 1'b0;
        attr_wa = slot_idx;
        attr_wd = {swapped, resident};

        unique case (state_reg)
            S_CLEAR:
            begin
                inl_we   = 1'b1;
                inl_wa   = clr_reg;
                inl_wd   = 1'b0;
                attr_we  = 1'b1;
                attr_wa  = clr_reg;
                attr_wd  = 2'b00;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    slot_next = slot_idx;
                    addr_next = page_address;
                    unique case (cmd)
                        lrupl_pkg::CMD_INSERT,
                        lrupl_pkg::CMD_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        lrupl_pkg::CMD_SET:
                        begin
                            attr_we   = slot_ok;
                            done_next = 1'b1;
                        end
                        lrupl_pkg::CMD_FIND:
                        begin
                            if (head_reg == NONE)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = head_reg[IDX_W-1:0];
                                cur_next   = head_reg;
                                steps_next = PTR_W'(1);
                                state_next = S_FIND;
                            end
                        end
                        lrupl_pkg::CMD_VICTIM:
                        begin
                            if (tail_reg == NONE)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = tail_reg[IDX_W-1:0];
                                cur_next   = tail_reg;
                                steps_next = PTR_W'(1);
                                state_next = S_VICTIM;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_UNLINK:
            begin
                if (inl_q[0])
                begin
                    if (prev_q < NONE)
                    begin
                        next_we = 1'b1;
                        next_wa = prev_q[IDX_W-1:0];
                        next_wd = next_q;
                    end
                    else
                    begin
                        head_next = next_q;
                    end
                    if (next_q < NONE)
                    begin
                        prev_we = 1'b1;
                        prev_wa = next_q[IDX_W-1:0];
                        prev_wd = prev_q;
                    end
                    else
                    begin
                        tail_next = prev_q;
                    end
                    inl_we = 1'b1;
                    inl_wd = 1'b0;
                end
                if (cmd_reg == lrupl_pkg::CMD_INSERT)
                begin
                    state_next = S_LINK_PREV;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_LINK_PREV:
            begin
                if (head_reg < NONE)
                begin
                    prev_we = 1'b1;
                    prev_wa = head_reg[IDX_W-1:0];
                    prev_wd = PTR_W'(slot_reg);
                end
                state_next = S_LINK_SELF;
            end

            S_LINK_SELF:
            begin
                next_we   = 1'b1;
                next_wd   = head_reg;
                prev_we   = 1'b1;
                prev_wd   = NONE;
                addr_we   = 1'b1;
                inl_we    = 1'b1;
                inl_wd    = 1'b1;
                head_next = PTR_W'(slot_reg);
                if (tail_reg == NONE)
                begin
                    tail_next = PTR_W'(slot_reg);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_FIND:
            begin
                rd_addr = next_q[IDX_W-1:0];
                if (addr_q == addr_reg)
                begin
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                    result_next = cur_wide[lrupl_pkg::SLOT_W-1:0];
                    state_next  = S_IDLE;
                end
                else if (next_q >= NONE || steps_reg == NONE)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = next_q;
                    steps_next = steps_reg + 1'b1;
                end
            end

            S_VICTIM:
            begin
                rd_addr = prev_q[IDX_W-1:0];
                if (!attr_q[1] && attr_q[0])
                begin
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                    result_next = cur_wide[lrupl_pkg::SLOT_W-1:0];
                    state_next  = S_IDLE;
                end
                else if (prev_q >= NONE || steps_reg == NONE)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = prev_q;
                    steps_next = steps_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            head_reg   <= NONE;
            tail_reg   <= NONE;
            cur_reg    <= '0;
            steps_reg  <= '0;
            cmd_reg    <= '0;
            slot_reg   <= '0;
            addr_reg   <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cur_reg    <= cur_next;
            steps_reg  <= steps_next;
            cmd_reg    <= cmd_next;
            slot_reg   <= slot_next;
            addr_reg   <= addr_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            result_reg <= result_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign result_slot = result_reg;

    a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> done)
        else $error("found raised without a result");

    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NONE) == (tail_reg == NONE))
        else $error("head and tail disagree on an empty list");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_VICTIM) |-> steps_reg <= NONE)
        else $error("list walk exceeded the slot count");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !done)
        else $error("result produced during the clearing pass");

endmodule

`default_nettype wire
